[hw/rtl/pidq_pkg.sv]
// Package of shared types and constants for the packet impairment delay queues.
package pidq_pkg;

  localparam int unsigned NumPlanes  = 8;
  localparam int unsigned QueueDepth = 32;
  localparam int unsigned PlaneW     = $clog2(NumPlanes);
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW      = PlaneW + PtrW;
  localparam int unsigned CntW       = $clog2(NumPlanes + 1);

  localparam logic [13:0] DropScale = 14'd10000;
  // ceil(2^44 / 10000): exact quotient for every 31-bit draw.
  localparam logic [30:0] DropRecip = 31'd1759218605;
  localparam logic [47:0] TimeMax   = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CfgPlaneCount  = 2'd0;
  localparam logic [1:0] CfgRandomPlane = 2'd1;
  localparam logic [1:0] CfgDropRate    = 2'd2;
  localparam logic [1:0] CfgDelayLimit  = 2'd3;

  localparam logic [1:0] StReleased = 2'd0;
  localparam logic [1:0] StDropped  = 2'd1;
  localparam logic [1:0] StQueued   = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic        action;
    logic [7:0]  packet_tag;
    logic [47:0] now_ns;
    logic [30:0] drop_draw;
    logic [30:0] delay_draw;
    logic [30:0] plane_draw;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_tag;
    logic [2:0] plane_index;
    logic       last;
  } out_word_t;

endpackage

[hw/rtl/packet_impairment_delay_queues.sv]
// Top level of the packet impairment delay queues.
// One word is handled at a time. The drop draw is reduced by 10000 with a
// reciprocal multiplication: the quotient is formed and registered first,
// then the remainder is formed and the drop decision is made. The delay draw
// (by the delay bound) and the plane draw (by the plane count) share one
// restoring divider that retires one quotient bit a cycle, 31 steps for each
// reduction that is needed. After a submission is accepted the block runs the
// drop multiply (only when the drop rate is non-zero) and the drop decision;
// a word that is not dropped then passes through the divider as needed, the
// release time, the plane choice and the enqueue. A poll reads the head of
// each plane in use from the queue memory, then compares and releases it; it
// then closes the scan and hands over the last released word, if any. A
// result that waits on a stalled output holds the block. The block then
// returns to idle, in which it takes the next word. The queue entries live in
// one synchronous memory of 256 words, 56 bits wide; head, tail and fill
// counts per plane are small register files cleared at reset. Results leave
// through an output register; the input is stalled while a word is worked.
module packet_impairment_delay_queues (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pidq_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pidq_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DROP  = 10'b0000000010,
    S_DLY   = 10'b0000000100,
    S_PLANE = 10'b0000001000,
    S_ENQ   = 10'b0000010000,
    S_PRD   = 10'b0000100000,
    S_PCHK  = 10'b0001000000,
    S_EMIT  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DMUL  = 10'b1000000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // Configuration.
  logic [3:0]  plane_count_q;
  logic        random_plane_q;
  logic [13:0] drop_rate_q;
  logic [39:0] delay_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q  <= 4'd1;
      random_plane_q <= 1'b0;
      drop_rate_q    <= '0;
      delay_limit_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pidq_pkg::CfgPlaneCount:  plane_count_q  <= cfg_data_i[3:0];
        pidq_pkg::CfgRandomPlane: random_plane_q <= cfg_data_i[0];
        pidq_pkg::CfgDropRate:    drop_rate_q    <= cfg_data_i[13:0];
        pidq_pkg::CfgDelayLimit:  delay_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Planes in use, clamped to 1..NumPlanes.
  logic [pidq_pkg::CntW-1:0] count;
  always_comb begin
    if (plane_count_q == 4'd0) begin
      count = pidq_pkg::CntW'(1);
    end else if (32'(plane_count_q) > pidq_pkg::NumPlanes) begin
      count = pidq_pkg::CntW'(pidq_pkg::NumPlanes);
    end else begin
      count = pidq_pkg::CntW'(plane_count_q);
    end
  end

  // Per-plane pointers and fill counts.
  logic [pidq_pkg::PtrW-1:0]  head_q [pidq_pkg::NumPlanes];
  logic [pidq_pkg::PtrW-1:0]  tail_q [pidq_pkg::NumPlanes];
  logic [pidq_pkg::FillW-1:0] fill_q [pidq_pkg::NumPlanes];
  logic [pidq_pkg::PlaneW-1:0] rr_q;

  // Queue memory: tag in the upper byte, release time below.
  logic [55:0] mem [pidq_pkg::NumPlanes * pidq_pkg::QueueDepth];
  logic                       mem_we;
  logic [pidq_pkg::AddrW-1:0] mem_waddr, mem_raddr;
  logic [55:0]                mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // Captured input word and working registers.
  pidq_pkg::in_word_t  item_q;
  logic [47:0]         rel_q, rel_d;
  logic [pidq_pkg::PlaneW-1:0] plane_q, plane_d;
  logic [pidq_pkg::CntW-1:0]   scan_q, scan_d;
  logic                        any_q, any_d;
  pidq_pkg::out_word_t pend_q, pend_d;
  logic                pend_last_q, pend_last_d;

  // Shared restoring divider: remainder of a 31-bit draw by a 40-bit divisor.
  logic [39:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [30:0] dvd_q, dvd_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [40:0] rem_sh;
  always_comb rem_sh = {rem_q, dvd_q[30]};

  // Drop draw modulo 10000 by reciprocal multiplication; the quotient is registered.
  logic [61:0] drop_prod;
  logic [17:0] drop_quot_q, drop_quot_d;
  logic [30:0] drop_sub;
  logic [13:0] drop_rem;
  always_comb drop_prod = dvd_q * pidq_pkg::DropRecip;
  always_comb drop_sub  = 31'(drop_quot_q * 31'(pidq_pkg::DropScale));
  always_comb drop_rem  = 14'(dvd_q - drop_sub);

  // Output register.
  logic                out_valid_q, out_valid_d;
  pidq_pkg::out_word_t out_q, out_d;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  logic [48:0] rel_sum;
  logic [pidq_pkg::PlaneW-1:0] scan_p;
  assign scan_p = scan_q[pidq_pkg::PlaneW-1:0];

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    rel_d = rel_q; plane_d = plane_q; scan_d = scan_q; any_d = any_q;
    pend_d = pend_q; pend_last_d = pend_last_q;
    rem_d = rem_q; dvs_d = dvs_q; dvd_d = dvd_q; dcnt_d = dcnt_q;
    drop_quot_d = drop_quot_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    mem_raddr = {scan_p, head_q[scan_p]};
    rel_sum = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.action) begin
            scan_d = '0; any_d = 1'b0; state_d = S_PRD;
          end else if (drop_rate_q != '0) begin
            dvd_d = in_data_i.drop_draw; state_d = S_DMUL;
          end else begin
            state_d = S_DROP;
          end
        end
      end
      S_DMUL: begin
        drop_quot_d = drop_prod[61:44];
        state_d = S_DROP;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = 40'(rem_sh - {1'b0, dvs_q});
        end else begin
          rem_d = rem_sh[39:0];
        end
        dvd_d = {dvd_q[29:0], 1'b0};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd30) begin
          state_d = ret_q;
        end
      end
      S_DROP: begin
        if (drop_rate_q != '0 && drop_rem < drop_rate_q) begin
          pend_d = '{status: pidq_pkg::StDropped, out_tag: item_q.packet_tag,
                     plane_index: '0, last: 1'b1};
          state_d = S_EMIT;
        end else if (delay_limit_q != '0) begin
          rem_d = '0; dvd_d = item_q.delay_draw; dcnt_d = '0;
          dvs_d = delay_limit_q; ret_d = S_DLY; state_d = S_DIV;
        end else begin
          rem_d = '0; state_d = S_DLY;
        end
      end
      S_DLY: begin
        rel_sum = {1'b0, item_q.now_ns} + 49'(rem_q);
        rel_d = rel_sum[48] ? pidq_pkg::TimeMax : rel_sum[47:0];
        if (random_plane_q) begin
          rem_d = '0; dvd_d = item_q.plane_draw; dcnt_d = '0;
          dvs_d = 40'(count); ret_d = S_PLANE; state_d = S_DIV;
        end else begin
          rem_d = 40'(rr_q); state_d = S_PLANE;
        end
      end
      S_PLANE: begin
        if (random_plane_q) begin
          plane_d = rem_q[pidq_pkg::PlaneW-1:0];
        end else begin
          plane_d = (pidq_pkg::CntW'(rr_q) < count) ? rr_q : '0;
        end
        state_d = S_ENQ;
      end
      S_ENQ: begin
        if (32'(fill_q[plane_q]) >= pidq_pkg::QueueDepth) begin
          pend_d = '{status: pidq_pkg::StFull, out_tag: item_q.packet_tag,
                     plane_index: 3'(plane_q), last: 1'b1};
        end else begin
          mem_we = 1'b1;
          mem_waddr = {plane_q, tail_q[plane_q]};
          mem_wdata = {item_q.packet_tag, rel_q};
          pend_d = '{status: pidq_pkg::StQueued, out_tag: item_q.packet_tag,
                     plane_index: 3'(plane_q), last: 1'b1};
        end
        state_d = S_EMIT;
      end
      S_PRD: begin
        // Head read issued this cycle; data is checked in the next.
        if (scan_q >= count) begin
          if (any_q) begin
            pend_last_d = 1'b1; state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        scan_d = scan_q + pidq_pkg::CntW'(1);
        state_d = S_PRD;
        if (fill_q[scan_p] != '0 && item_q.now_ns >= mem_rdata_q[47:0]) begin
          // A due head: the previous pending release goes out first.
          if (any_q) begin
            if (out_free) begin
              out_valid_d = 1'b1; out_d = pend_q;
            end else begin
              scan_d = scan_q; state_d = S_PCHK;
            end
          end
          if (!any_q || out_free) begin
            any_d = 1'b1;
            pend_d = '{status: pidq_pkg::StReleased,
                       out_tag: mem_rdata_q[55:48],
                       plane_index: 3'(scan_p), last: 1'b0};
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = pend_q;
          if (pend_last_q) out_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pointer and fill updates happen where the state machine commits them.
  logic rel_commit, enq_commit;
  assign rel_commit = (state_q == S_PCHK) && fill_q[scan_p] != '0 &&
                      item_q.now_ns >= mem_rdata_q[47:0] && (!any_q || out_free);
  assign enq_commit = mem_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE;
      out_valid_q <= 1'b0; rr_q <= '0;
      scan_q <= '0; any_q <= 1'b0; pend_last_q <= 1'b0;
      for (int i = 0; i < pidq_pkg::NumPlanes; i++) begin
        head_q[i] <= '0; tail_q[i] <= '0; fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      out_valid_q <= out_valid_d;
      scan_q <= scan_d; any_q <= any_d;
      pend_last_q <= (state_q == S_IDLE) ? 1'b0 : pend_last_d;
      if (state_q == S_PLANE && !random_plane_q) begin
        rr_q <= (pidq_pkg::CntW'(plane_d) + pidq_pkg::CntW'(1) >= count) ? '0
                : pidq_pkg::PlaneW'(plane_d + pidq_pkg::PlaneW'(1));
      end
      if (enq_commit) begin
        tail_q[plane_q] <= tail_q[plane_q] + pidq_pkg::PtrW'(1);
        fill_q[plane_q] <= fill_q[plane_q] + pidq_pkg::FillW'(1);
      end
      if (rel_commit) begin
        head_q[scan_p] <= head_q[scan_p] + pidq_pkg::PtrW'(1);
        fill_q[scan_p] <= fill_q[scan_p] - pidq_pkg::FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    rel_q <= rel_d; plane_q <= plane_d; pend_q <= pend_d;
    rem_q <= rem_d; dvs_q <= dvs_d; dvd_q <= dvd_d; dcnt_q <= dcnt_d;
    drop_quot_q <= drop_quot_d;
    out_q <= out_d;
  end

endmodule

[dv/tb_packet_impairment_delay_queues.sv]
// Testbench for the packet impairment delay queues: directed and random words against a predictor.
module tb_packet_impairment_delay_queues;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 120;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pidq_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  pidq_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [39:0]         cfg_data;

  // The predictor keeps its own copy of the registers and the queues.
  logic [3:0]  pred_plane_count;
  logic        pred_random_plane;
  logic [13:0] pred_drop_rate;
  logic [39:0] pred_delay_limit;
  logic [7:0]  slot_tag [pidq_pkg::NumPlanes][pidq_pkg::QueueDepth];
  logic [47:0] slot_due [pidq_pkg::NumPlanes][pidq_pkg::QueueDepth];
  int unsigned head_idx [pidq_pkg::NumPlanes];
  int unsigned tail_idx [pidq_pkg::NumPlanes];
  int unsigned fill_cnt [pidq_pkg::NumPlanes];
  int unsigned rr_plane;

  pidq_pkg::out_word_t expected_words[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idle_enabled;

  packet_impairment_delay_queues u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // A hard limit on the length of the run, so that a hung block still ends it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int unsigned planes_active();
    if (pred_plane_count == 0) return 1;
    if (pred_plane_count > pidq_pkg::NumPlanes) return pidq_pkg::NumPlanes;
    return pred_plane_count;
  endfunction

  function automatic pidq_pkg::out_word_t make_word(logic [1:0] st, logic [7:0] tag,
                                                    int unsigned plane, logic lst);
    pidq_pkg::out_word_t w;
    w.status      = st;
    w.out_tag     = tag;
    w.plane_index = plane[2:0];
    w.last        = lst;
    return w;
  endfunction

  // Works out the result words a word causes and updates the predicted queues.
  task automatic predict_release(input pidq_pkg::in_word_t w);
    int unsigned count;
    int unsigned plane;
    int unsigned n;
    logic [48:0] due;
    logic [39:0] delay;
    pidq_pkg::out_word_t res;
    count = planes_active();
    n = 0;
    if (w.action) begin
      for (int unsigned p = 0; p < count; p++) begin
        if (fill_cnt[p] != 0 && w.now_ns >= slot_due[p][head_idx[p]]) begin
          expected_words.push_back(make_word(pidq_pkg::StReleased,
                                             slot_tag[p][head_idx[p]], p, 1'b0));
          head_idx[p] = (head_idx[p] + 1) % pidq_pkg::QueueDepth;
          fill_cnt[p]--;
          n++;
        end
      end
      if (n > 0) begin
        res = expected_words[$];
        res.last = 1'b1;
        expected_words[$] = res;
      end
      return;
    end
    if (pred_drop_rate != 0 && (w.drop_draw % 10000) < pred_drop_rate) begin
      expected_words.push_back(make_word(pidq_pkg::StDropped, w.packet_tag, 0, 1'b1));
      return;
    end
    delay = (pred_delay_limit != 0) ? 40'(64'(w.delay_draw) % 64'(pred_delay_limit)) : 40'd0;
    due = {1'b0, w.now_ns} + 49'(delay);
    if (due > {1'b0, pidq_pkg::TimeMax}) due = {1'b0, pidq_pkg::TimeMax};
    if (pred_random_plane) begin
      plane = w.plane_draw % count;
    end else begin
      plane = (rr_plane < count) ? rr_plane : 0;
      rr_plane = (plane + 1 >= count) ? 0 : plane + 1;
    end
    if (fill_cnt[plane] >= pidq_pkg::QueueDepth) begin
      expected_words.push_back(make_word(pidq_pkg::StFull, w.packet_tag, plane, 1'b1));
      return;
    end
    slot_tag[plane][tail_idx[plane]] = w.packet_tag;
    slot_due[plane][tail_idx[plane]] = due[47:0];
    tail_idx[plane] = (tail_idx[plane] + 1) % pidq_pkg::QueueDepth;
    fill_cnt[plane]++;
    expected_words.push_back(make_word(pidq_pkg::StQueued, w.packet_tag, plane, 1'b1));
  endtask

  // Checking process: every accepted output word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", out_data));
      end else begin
        pidq_pkg::out_word_t exp_w;
        exp_w = expected_words.pop_front();
        if (out_data.status !== exp_w.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, exp_w.status));
        if (out_data.out_tag !== exp_w.out_tag)
          report_mismatch($sformatf("tag %0d, expected %0d", out_data.out_tag, exp_w.out_tag));
        if (out_data.plane_index !== exp_w.plane_index)
          report_mismatch($sformatf("plane %0d, expected %0d", out_data.plane_index,
                                    exp_w.plane_index));
        if (out_data.last !== exp_w.last)
          report_mismatch($sformatf("last %0d, expected %0d", out_data.last, exp_w.last));
      end
    end
  end

  // The receiver stalls about a third of the time unless idling is switched off.
  always @(posedge clk) begin
    out_stall <= idle_enabled && ($urandom_range(99) < 32);
  end

  // Valid is dropped at the accepting edge and raised no earlier than the next one.
  task automatic send_word(input pidq_pkg::in_word_t w);
    @(posedge clk);
    while (idle_enabled && $urandom_range(99) < 32) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    predict_release(w);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Registers are written only while the block is idle; configure drops the enable.
  task automatic write_reg(input logic [1:0] idx, input logic [39:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      pidq_pkg::CfgPlaneCount:  pred_plane_count  = value[3:0];
      pidq_pkg::CfgRandomPlane: pred_random_plane = value[0];
      pidq_pkg::CfgDropRate:    pred_drop_rate    = value[13:0];
      pidq_pkg::CfgDelayLimit:  pred_delay_limit  = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] planes, input logic rnd, input logic [13:0] drop,
                           input logic [39:0] delay);
    wait_drained();
    write_reg(pidq_pkg::CfgPlaneCount, 40'(planes));
    write_reg(pidq_pkg::CfgRandomPlane, 40'(rnd));
    write_reg(pidq_pkg::CfgDropRate, 40'(drop));
    write_reg(pidq_pkg::CfgDelayLimit, delay);
    cfg_we <= 1'b0;
  endtask

  function automatic pidq_pkg::in_word_t random_word(logic act, logic [47:0] now);
    pidq_pkg::in_word_t w;
    w.action     = act;
    w.packet_tag = 8'($urandom);
    w.now_ns     = now;
    w.drop_draw  = 31'($urandom);
    w.delay_draw = 31'($urandom);
    w.plane_draw = 31'($urandom);
    return w;
  endfunction

  // Directed: field extremes, both actions, drops, saturation, full queue, empty poll.
  task automatic test_directed();
    pidq_pkg::in_word_t w;
    w = random_word(1'b1, 48'd0);
    send_word(w);                              // poll with nothing queued
    w = '0;
    send_word(w);                              // minimum fields, plane 0
    w = '1;
    w.action = 1'b0;
    send_word(w);                              // maximum fields
    w.action = 1'b1;
    send_word(w);                              // release the head of plane 0
    configure(4'd8, 1'b0, 14'd10000, 40'd0);   // everything dropped
    send_word(random_word(1'b0, 48'd5));
    configure(4'd0, 1'b0, 14'h3FFF, 40'hFF_FFFF_FFFF);
    send_word(random_word(1'b0, 48'd5));       // drop rate above scale
    configure(4'd15, 1'b0, 14'd0, 40'hFF_FFFF_FFFF);
    for (int i = 0; i < 9; i++) begin          // count above the planes, wrap and saturate
      w = random_word(1'b0, pidq_pkg::TimeMax - 48'(i));
      w.delay_draw = 31'h7FFF_FFFF;
      send_word(w);
    end
    send_word(random_word(1'b1, pidq_pkg::TimeMax));
    configure(4'd1, 1'b0, 14'd0, 40'd1);
    for (int i = 0; i < 34; i++) send_word(random_word(1'b0, 48'd100)); // fill past depth
    configure(4'd2, 1'b0, 14'd0, 40'd1);       // raise the count and poll
    for (int i = 0; i < 33; i++) send_word(random_word(1'b1, 48'd100));
  endtask

  // Random phases, mostly submissions and polls over advancing time.
  task automatic test_random();
    logic [47:0] now;
    for (int phase = 0; phase < 8; phase++) begin
      configure(4'($urandom_range(9)), 1'($urandom), 14'($urandom_range(phase[0] ? 3000 : 0)),
                (phase == 3) ? 40'hFF_FFFF_FFFF : 40'($urandom_range(5000)));
      idle_enabled = (phase != 2);
      now = (phase == 5) ? pidq_pkg::TimeMax - 48'd20000 : 48'($urandom) << 8;
      for (int i = 0; i < 28; i++) begin
        now = now + 48'($urandom_range(400));
        send_word(random_word(1'($urandom_range(99) < 40), now));
      end
      send_word(random_word(1'b1, pidq_pkg::TimeMax));
      if (phase == 4) wait_drained();           // sender holds off until all results are back
    end
    idle_enabled = 1'b1;
    configure(4'd8, 1'b1, 14'd0, 40'd0);       // release the head of every plane
    send_word(random_word(1'b1, pidq_pkg::TimeMax));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pidq_pkg::CfgPlaneCount;
    cfg_data = '0;
    cycle_count = 0;
    mismatches = 0;
    idle_enabled = 1'b1;
    pred_plane_count = 4'd1;
    pred_random_plane = 1'b0;
    pred_drop_rate = '0;
    pred_delay_limit = '0;
    rr_plane = 0;
    for (int p = 0; p < pidq_pkg::NumPlanes; p++) begin
      head_idx[p] = 0;
      tail_idx[p] = 0;
      fill_cnt[p] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
